@@ rtl/hsl_to_rgb_converter_assert.svh @@
// Assertion macros for the HSL to RGB converter.
// Needs clk and rst_n in the scope of each use.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSL2RGB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsl_to_rgb_converter: implication check failed");

// Next-cycle implication, disabled during reset.
`define HSL2RGB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsl_to_rgb_converter: next-cycle check failed");

`endif

@@ rtl/hsl2rgb_pkg.sv @@
// Shared types, constants and helpers for the HSL to RGB converter.
// No dependencies.
package hsl2rgb_pkg;

    localparam int HueW   = 12;
    localparam int FracW  = 13;
    localparam int FracBits = 12;
    localparam int ChanW  = 8;
    localparam int PosW   = 10;
    localparam int QpW    = 28;
    localparam int ProdW  = 39;
    localparam int NumW   = 40;
    localparam int MulW   = NumW + 8;
    localparam int ShiftOut = 33;

    typedef logic [HueW-1:0]          hue_t;
    typedef logic [HueW:0]            hsum_t;
    typedef logic [FracW-1:0]         frac_t;
    typedef logic [ChanW-1:0]         chan_t;
    typedef logic [PosW-1:0]          pos_t;
    typedef logic signed [QpW-1:0]    qp_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [NumW-1:0]   num_t;

    localparam hsum_t HueTurn      = 13'd3072;
    localparam hsum_t HueThird     = 13'd1024;
    localparam hsum_t HueSixth     = 13'd512;
    localparam hsum_t HueHalf      = 13'd1536;
    localparam hsum_t HueTwoThirds = 13'd2048;
    localparam frac_t HalfUnit     = 13'd2048;
    localparam pos_t  PosFull      = 10'd512;

    // Reduce a hue sum below one turn (input is below two turns).
    function automatic hue_t wrap_turn(hsum_t x);
        hsum_t r;
        r = (x >= HueTurn) ? (x - HueTurn) : x;
        return r[HueW-1:0];
    endfunction

    // Multiplier for (q - p) on the hue ramp: rising, flat, falling, low.
    function automatic pos_t ramp_pos(hue_t t);
        hsum_t r;
        r = HueTwoThirds - hsum_t'(t);
        if (hsum_t'(t) < HueSixth)
            return t[PosW-1:0];
        else if (hsum_t'(t) < HueHalf)
            return PosFull;
        else if (hsum_t'(t) < HueTwoThirds)
            return r[PosW-1:0];
        else
            return '0;
    endfunction

endpackage

@@ rtl/hsl2rgb_if.sv @@
// Stream interfaces for HSL pixels in and RGB pixels out.
// Depends on hsl2rgb_pkg.
interface hsl2rgb_in_if;
    import hsl2rgb_pkg::*;

    logic  valid;
    logic  ready;
    hue_t  hue;
    frac_t saturation;
    frac_t lightness;

    modport source (output valid, hue, saturation, lightness, input ready);
    modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hsl2rgb_out_if;
    import hsl2rgb_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/hsl2rgb_channel.sv @@
// One colour channel: ramp multiply, accumulate, scale by 255 and clamp; gray on zero saturation.
// Three register stages; depends on hsl2rgb_pkg.
module hsl2rgb_channel (
    input  logic                clk,
    input  logic                en,
    input  hsl2rgb_pkg::qp_t    p,
    input  hsl2rgb_pkg::qp_t    d,
    input  hsl2rgb_pkg::pos_t   u,
    input  hsl2rgb_pkg::chan_t  gray,
    input  logic                zero,
    output hsl2rgb_pkg::chan_t  chan
);
    import hsl2rgb_pkg::*;

    prod_t prod_reg, prod_next;
    qp_t   p_reg;
    num_t  num_reg, num_next;
    chan_t gray4_reg, gray5_reg;
    logic  zero4_reg, zero5_reg;
    chan_t chan_reg, chan_next;

    logic [MulW-1:0]         scaled;
    logic [MulW-ShiftOut-1:0] hi;

    always_comb
    begin
        prod_next = prod_t'(d) * prod_t'($signed({1'b0, u}));
        num_next  = (num_t'(p_reg) <<< 9) + num_t'(prod_reg);
        // x*255 as (x << 8) - x; only used for positive x
        scaled    = {num_reg, 8'b0} - {{8{num_reg[NumW-1]}}, num_reg};
        hi        = scaled[MulW-1:ShiftOut];
        if (zero5_reg)
            chan_next = gray5_reg;
        else if (num_reg[NumW-1] || (num_reg == '0))
            chan_next = '0;
        else if (hi > (MulW-ShiftOut)'(255))
            chan_next = '1;
        else
            chan_next = hi[ChanW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            p_reg     <= p;
            gray4_reg <= gray;
            zero4_reg <= zero;
            num_reg   <= num_next;
            gray5_reg <= gray4_reg;
            zero5_reg <= zero4_reg;
            chan_reg  <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

@@ rtl/hsl_to_rgb_converter.sv @@
// HSL to 8-bit RGB converter, six-stage pipeline, top level.
// Depends on hsl2rgb_pkg, hsl2rgb_if, hsl2rgb_channel and the assert header.
//
//  port     | dir  | transaction payload
//  ---------+------+--------------------------------------------
//  pix_in   | sink | hue[11:0], saturation[12:0], lightness[12:0]
//  pix_out  | src  | red[7:0], green[7:0], blue[7:0]
//
// One transaction in per clock while the output is not held. The depth is set by
// the lightness x saturation multiply, the q/p adders and the per-channel ramp
// multiply, accumulate and scale.
// rst_n clears only the stage valid bits; data registers are not reset.
// A held output freezes every stage together, so nothing is lost or repeated;
// pix_in.ready drops only while the output register holds an untaken result.
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter (
    input  logic          clk,
    input  logic          rst_n,
    hsl2rgb_in_if.sink    pix_in,
    hsl2rgb_out_if.source pix_out
);
    import hsl2rgb_pkg::*;

    localparam int Stages = 6;

    // stage valid bits; the top bit is the output register
    logic [Stages-1:0] vld_reg, vld_next;
    logic              en;

    // stage 1: hue reduction, channel positions, l*s, gray value
    hue_t               t_next [3];
    hue_t               t1_reg [3];
    logic [2*FracW-1:0] ls1_reg, ls_next;
    frac_t              l1_reg;
    frac_t              s1_reg;
    logic               low1_reg, low_next;
    logic               z1_reg, z_next;
    chan_t              gray1_reg, gray_next;
    hue_t               hr;
    logic [FracW+7:0]   gm;
    logic [8:0]         g9;

    // stage 2: q and ramp multipliers
    qp_t   q2_reg, q_next;
    pos_t  u2_reg [3];
    pos_t  u_next [3];
    frac_t l2_reg;
    logic  z2_reg;
    chan_t gray2_reg;
    qp_t   lq, sq, lsq;

    // stage 3: p and q - p
    qp_t   p3_reg, p_next;
    qp_t   d3_reg, d_next;
    pos_t  u3_reg [3];
    logic  z3_reg;
    chan_t gray3_reg;

    // zero-saturation flag carried to the output for checking
    logic  z4_reg, z5_reg, z6_reg;

    assign en           = !vld_reg[Stages-1] || pix_out.ready;
    assign pix_in.ready = en;
    assign vld_next     = {vld_reg[Stages-2:0], pix_in.valid};

    always_comb
    begin
        hr        = wrap_turn({1'b0, pix_in.hue});
        // red at hue + 1/3, green at hue, blue at hue - 1/3 (as + 2/3)
        t_next[0] = wrap_turn(hsum_t'(hr) + HueThird);
        t_next[1] = hr;
        t_next[2] = wrap_turn(hsum_t'(hr) + HueTwoThirds);
        ls_next   = {{FracW{1'b0}}, pix_in.lightness} * {{FracW{1'b0}}, pix_in.saturation};
        low_next  = pix_in.lightness < HalfUnit;
        z_next    = pix_in.saturation == '0;
        gm        = {pix_in.lightness, 8'b0} - {8'b0, pix_in.lightness};
        g9        = gm[FracW+7:FracBits];
        gray_next = g9[8] ? '1 : g9[ChanW-1:0];
    end

    always_comb
    begin
        lq  = qp_t'({l1_reg, 12'b0});
        sq  = qp_t'({s1_reg, 12'b0});
        lsq = qp_t'(ls1_reg);
        // q = l(1+s) below half lightness, else l + s - ls
        q_next = low1_reg ? (lq + lsq) : (lq + sq - lsq);
        for (int c = 0; c < 3; c++)
            u_next[c] = ramp_pos(t1_reg[c]);
        p_next = qp_t'({l2_reg, 13'b0}) - q2_reg;
        d_next = q2_reg - p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= t_next;
            ls1_reg   <= ls_next;
            l1_reg    <= pix_in.lightness;
            s1_reg    <= pix_in.saturation;
            low1_reg  <= low_next;
            z1_reg    <= z_next;
            gray1_reg <= gray_next;

            q2_reg    <= q_next;
            u2_reg    <= u_next;
            l2_reg    <= l1_reg;
            z2_reg    <= z1_reg;
            gray2_reg <= gray1_reg;

            p3_reg    <= p_next;
            d3_reg    <= d_next;
            u3_reg    <= u2_reg;
            z3_reg    <= z2_reg;
            gray3_reg <= gray2_reg;

            z4_reg    <= z3_reg;
            z5_reg    <= z4_reg;
            z6_reg    <= z5_reg;
        end
    end

    hsl2rgb_channel u_red (
        .clk  (clk),
        .en   (en),
        .p    (p3_reg),
        .d    (d3_reg),
        .u    (u3_reg[0]),
        .gray (gray3_reg),
        .zero (z3_reg),
        .chan (pix_out.red)
    );

    hsl2rgb_channel u_green (
        .clk  (clk),
        .en   (en),
        .p    (p3_reg),
        .d    (d3_reg),
        .u    (u3_reg[1]),
        .gray (gray3_reg),
        .zero (z3_reg),
        .chan (pix_out.green)
    );

    hsl2rgb_channel u_blue (
        .clk  (clk),
        .en   (en),
        .p    (p3_reg),
        .d    (d3_reg),
        .u    (u3_reg[2]),
        .gray (gray3_reg),
        .zero (z3_reg),
        .chan (pix_out.blue)
    );

    assign pix_out.valid = vld_reg[Stages-1];

    // a taken pixel reaches the output once it has advanced through every stage
    `HSL2RGB_ASSERT_NXT(a_latency, (pix_in.valid && pix_in.ready) ##1 en ##1 en ##1 en ##1 en ##1 en, vld_reg[Stages-1])
    // zero saturation gives gray on all three channels
    `HSL2RGB_ASSERT_IMP(a_gray, vld_reg[Stages-1] && z6_reg, (pix_out.red == pix_out.green) && (pix_out.green == pix_out.blue))

endmodule

@@ tb/hsl_to_rgb_converter_tb.sv @@
// Self-checking testbench for hsl_to_rgb_converter: directed corner pixels, then random ones.
// Each result is checked against a predictor held here.
// Depends on hsl2rgb_pkg, hsl2rgb_if and the converter RTL.
module hsl_to_rgb_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    // Watchdog: cycles with no transaction on either side before giving up.
    localparam int StallLimit = 2000;
    // Cycles to wait after the last result, well past the six-stage latency.
    localparam int DrainCycles = 20;
    // The long output hold starts once this many pixels have gone in.
    localparam int HoldAt = 400;
    localparam int HoldLen = 90;
    // Both sides run without idling while this many pixels go in.
    localparam int CalmFrom = 900;
    localparam int CalmTo = 1300;
    localparam int RandomPixels = 2000;

    // Fixed-point turn and unit, as the block uses them.
    localparam longint Turn = 3072;
    localparam longint Third = 1024;
    localparam longint Sixth = 512;
    localparam longint HalfTurn = 1536;
    localparam longint TwoThirds = 2048;
    localparam longint Unit = 4096;
    localparam longint HalfFrac = 2048;

    typedef struct {
        hue_t  hue;
        frac_t saturation;
        frac_t lightness;
        bit    wait_empty;  // hold this pixel back until the pipeline has emptied
    } hsl_pixel_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_pixel_t;

    logic clk;
    logic rst_n;

    hsl2rgb_in_if  pix_in();
    hsl2rgb_out_if pix_out();

    hsl_to_rgb_converter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    hsl_pixel_t pending_pixels[$];
    rgb_pixel_t expected_rgb[$];

    int   pixels_sent;
    int   results_seen;
    int   error_count;
    int   hold_left;
    bit   hold_done;
    int   quiet_cycles;
    logic calm_stretch;

    assign calm_stretch = (pixels_sent >= CalmFrom) && (pixels_sent < CalmTo);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Piecewise-linear hue ramp; result in units of 2^-33.
    function automatic longint ramp_level(longint p24, longint q24, longint t);
        if (t < Sixth)
            return p24 * Sixth + (q24 - p24) * t;
        else if (t < HalfTurn)
            return q24 * Sixth;
        else if (t < TwoThirds)
            return p24 * Sixth + (q24 - p24) * (TwoThirds - t);
        else
            return p24 * Sixth;
    endfunction

    // Scale by 255 and truncate, clamping below 0 and above 255.
    function automatic chan_t scale_channel(longint level);
        longint v;
        if (level <= 0)
            return '0;
        v = (level * 255) >> 33;
        return (v > 255) ? chan_t'(255) : chan_t'(v);
    endfunction

    function automatic rgb_pixel_t predict_rgb(hue_t hue, frac_t sat, frac_t light);
        longint h;
        longint s;
        longint l;
        longint q24;
        longint p24;
        longint grey;
        rgb_pixel_t px;
        h = longint'(hue) % Turn;
        s = longint'(sat);
        l = longint'(light);
        if (s == 0)
        begin
            // Grey: no ramp at all, lightness straight to every channel.
            grey = (l * 255) >> 12;
            px.red = (grey > 255) ? chan_t'(255) : chan_t'(grey);
            px.green = px.red;
            px.blue = px.red;
            return px;
        end
        if (l < HalfFrac)
            q24 = l * (Unit + s);
        else
            q24 = l * Unit + s * Unit - l * s;
        p24 = 2 * l * Unit - q24;
        px.red = scale_channel(ramp_level(p24, q24, (h + Third) % Turn));
        px.green = scale_channel(ramp_level(p24, q24, h));
        px.blue = scale_channel(ramp_level(p24, q24, (h + Turn - Third) % Turn));
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int idx, int got, int want);
        $display("MISMATCH result %0d: %s got %0d, expected %0d", idx, what, got, want);
        error_count++;
    endtask

    task automatic queue_pixel(int hue, int sat, int light, bit wait_empty);
        hsl_pixel_t px;
        px.hue = hue_t'(hue);
        px.saturation = frac_t'(sat);
        px.lightness = frac_t'(light);
        px.wait_empty = wait_empty;
        pending_pixels.push_back(px);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input driver: one pixel per transaction, held until taken.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : pixel_driver
        bit offer;
        if (rst_n)
        begin
            // The pixel on the bus is taken at this edge: work out its colour now.
            if (pix_in.valid && pix_in.ready)
            begin
                expected_rgb.push_back(predict_rgb(pix_in.hue, pix_in.saturation,
                                                   pix_in.lightness));
                pixels_sent++;
            end
            // Bus free: decide whether to present the next pixel or idle.
            if (!pix_in.valid || pix_in.ready)
            begin
                offer = 1'b0;
                if (pending_pixels.size() > 0)
                begin
                    offer = 1'b1;
                    if (pending_pixels[0].wait_empty && expected_rgb.size() > 0)
                        offer = 1'b0;
                    // Keep offering during the long output hold so the pipe fills.
                    else if (!calm_stretch && hold_left == 0 && $urandom_range(99) < 23)
                        offer = 1'b0;
                end
                if (offer)
                begin
                    pix_in.hue <= pending_pixels[0].hue;
                    pix_in.saturation <= pending_pixels[0].saturation;
                    pix_in.lightness <= pending_pixels[0].lightness;
                    pix_in.valid <= 1'b1;
                    void'(pending_pixels.pop_front());
                end
                else
                    pix_in.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && pixels_sent >= HoldAt)
            begin
                hold_left = HoldLen;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else if (calm_stretch)
                pix_out.ready <= 1'b1;
            else
                pix_out.ready <= ($urandom_range(99) >= 23);
        end
    end

    // Monitor: compare each RGB transaction with the oldest prediction.
    always @(posedge clk)
    begin : rgb_monitor
        rgb_pixel_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                $display("UNEXPECTED result %0d: r=%0d g=%0d b=%0d", results_seen,
                         pix_out.red, pix_out.green, pix_out.blue);
                error_count++;
            end
            else
            begin
                want = expected_rgb.pop_front();
                if (pix_out.red !== want.red)
                    report_mismatch("red", results_seen, pix_out.red, want.red);
                if (pix_out.green !== want.green)
                    report_mismatch("green", results_seen, pix_out.green, want.green);
                if (pix_out.blue !== want.blue)
                    report_mismatch("blue", results_seen, pix_out.blue, want.blue);
            end
            results_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("TIMEOUT after %0d idle cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int sel;
        int hue;
        int sat;
        int light;

        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.hue = '0;
        pix_in.saturation = '0;
        pix_in.lightness = '0;
        pix_out.ready = 1'b0;
        pixels_sent = 0;
        results_seen = 0;
        error_count = 0;
        hold_left = 0;
        hold_done = 1'b0;
        quiet_cycles = 0;

        // Directed corners: primaries, grey, ramp breakpoints, wrap, overrange.
        queue_pixel(0, 4096, 2048, 1'b0);     // pure red
        queue_pixel(1024, 4096, 2048, 1'b0);  // pure green
        queue_pixel(2048, 4096, 2048, 1'b0);  // pure blue
        queue_pixel(511, 4096, 2048, 1'b0);   // either side of each ramp knee
        queue_pixel(512, 4096, 2048, 1'b0);
        queue_pixel(1535, 4096, 2048, 1'b0);
        queue_pixel(1536, 4096, 2048, 1'b0);
        queue_pixel(2047, 4096, 2048, 1'b0);
        queue_pixel(3071, 4096, 2048, 1'b0);
        queue_pixel(3072, 4096, 2048, 1'b0);  // hue past one turn wraps
        queue_pixel(4095, 3000, 1500, 1'b0);
        queue_pixel(0, 0, 0, 1'b0);           // grey: black, white, clamped
        queue_pixel(700, 0, 4096, 1'b0);
        queue_pixel(4095, 0, 8191, 1'b0);
        queue_pixel(2000, 0, 1234, 1'b0);
        queue_pixel(300, 4096, 4096, 1'b0);   // white
        queue_pixel(300, 4096, 0, 1'b0);      // black
        queue_pixel(900, 3000, 2047, 1'b0);   // lightness either side of one half
        queue_pixel(900, 3000, 2048, 1'b0);
        queue_pixel(100, 1, 1, 1'b0);
        queue_pixel(1700, 8191, 1000, 1'b0);  // saturation over range
        queue_pixel(2500, 8191, 8191, 1'b0);  // both over range
        queue_pixel(200, 5000, 6000, 1'b0);   // p goes over one, clamps to 255
        queue_pixel(2800, 1, 8191, 1'b0);

        // Random pixels; the first waits for the directed set to drain, and a
        // second pause falls late in the run.
        for (int i = 0; i < RandomPixels; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                hue = $urandom_range(3071);
                sat = $urandom_range(4096);
                light = $urandom_range(4096);
            end
            else if (sel < 77)
            begin
                hue = $urandom_range(4095);
                sat = 0;
                light = $urandom_range(8191);
            end
            else if (sel < 85)
            begin
                // land on or beside a breakpoint
                hue = (512 * $urandom_range(6)) + $urandom_range(2) - 1;
                if (hue < 0)
                    hue = 0;
                sat = $urandom_range(4096);
                light = $urandom_range(4096);
            end
            else
            begin
                // full field range: every bit both ways
                hue = $urandom_range(4095);
                sat = $urandom_range(8191);
                light = $urandom_range(8191);
            end
            queue_pixel(hue, sat, light, (i == 0) || (i == 1600));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every pixel to go in and every colour to come back.
        while (pending_pixels.size() > 0 || pix_in.valid || expected_rgb.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
